@@ sv/pcfc_pkg.sv @@
package pcfc_pkg;

  // Default widths; the top level carries the live parameters.
  localparam int unsigned COUNT_WIDTH_DEF    = 16;
  localparam int unsigned LOCATION_WIDTH_DEF = 32;

  // Fixed field widths.
  localparam int unsigned REF_WIDTH   = 8;
  localparam int unsigned DELTA_WIDTH = 33;
  localparam int unsigned REP_WIDTH   = 8;

  // Bases, indexed 1..5 as in the ".ACGTN" letter string.
  localparam int unsigned NUM_BASES = 5;
  localparam int unsigned IDX_WIDTH = 3;

  localparam logic [IDX_WIDTH-1:0] BASE_NONE = 3'd0;
  localparam logic [IDX_WIDTH-1:0] BASE_A    = 3'd1;
  localparam logic [IDX_WIDTH-1:0] BASE_C    = 3'd2;
  localparam logic [IDX_WIDTH-1:0] BASE_G    = 3'd3;
  localparam logic [IDX_WIDTH-1:0] BASE_T    = 3'd4;
  localparam logic [IDX_WIDTH-1:0] BASE_N    = 3'd5;

  // Allelic replacement code: ALLELIC_BASE + ALLELIC_MUL*first + second.
  localparam int unsigned ALLELIC_BASE = 85;
  localparam int unsigned ALLELIC_MUL  = 6;

  // Allelic test: ALLELIC_DEN*second > sum, i.e. second/sum > 0.2.
  localparam int unsigned ALLELIC_DEN = 5;

  // Per-site call handed from the classifier to the top level.
  typedef struct packed {
    logic                 fix;
    logic                 allelic;
    logic [REP_WIDTH-1:0] replacement;
  } pcfc_call_t;

  function automatic logic [REF_WIDTH-1:0] base_letter(input logic [IDX_WIDTH-1:0] idx);
    logic [REF_WIDTH-1:0] letter;
    case (idx)
      BASE_A:  letter = 8'h41;
      BASE_C:  letter = 8'h43;
      BASE_G:  letter = 8'h47;
      BASE_T:  letter = 8'h54;
      BASE_N:  letter = 8'h4E;
      default: letter = 8'h2E;
    endcase
    return letter;
  endfunction

endpackage

@@ sv/pcfc_site_if.sv @@
interface pcfc_site_if #(
  parameter int unsigned COUNT_WIDTH    = pcfc_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned LOCATION_WIDTH = pcfc_pkg::LOCATION_WIDTH_DEF
) ();
  import pcfc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [LOCATION_WIDTH-1:0] location;
  logic [REF_WIDTH-1:0]      ref_char;
  logic [COUNT_WIDTH-1:0]    count_a;
  logic [COUNT_WIDTH-1:0]    count_c;
  logic [COUNT_WIDTH-1:0]    count_g;
  logic [COUNT_WIDTH-1:0]    count_t;
  logic [COUNT_WIDTH-1:0]    count_n;
  logic                      block_start;

  modport source (
    output valid, location, ref_char, count_a, count_c, count_g, count_t, count_n,
           block_start,
    input  ready
  );

  modport sink (
    input  valid, location, ref_char, count_a, count_c, count_g, count_t, count_n,
           block_start,
    output ready
  );

endinterface

@@ sv/pcfc_fix_if.sv @@
interface pcfc_fix_if ();
  import pcfc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   fix_valid;
  logic [DELTA_WIDTH-1:0] loc_delta;
  logic [REP_WIDTH-1:0]   replacement;
  logic                   is_allelic;

  modport source (
    output valid, fix_valid, loc_delta, replacement, is_allelic,
    input  ready
  );

  modport sink (
    input  valid, fix_valid, loc_delta, replacement, is_allelic,
    output ready
  );

endinterface

@@ sv/pcfc_classify.sv @@
module pcfc_classify #(
  parameter int unsigned COUNT_WIDTH = pcfc_pkg::COUNT_WIDTH_DEF
) (
  input  logic [pcfc_pkg::REF_WIDTH-1:0] ref_char_i,
  input  logic [COUNT_WIDTH-1:0]         counts_i [pcfc_pkg::NUM_BASES],
  output pcfc_pkg::pcfc_call_t           call_o
);
  import pcfc_pkg::*;

  localparam int unsigned SUM_WIDTH = COUNT_WIDTH + 3;

  logic [COUNT_WIDTH-1:0] best;
  logic [COUNT_WIDTH-1:0] second;
  logic [IDX_WIDTH-1:0]   first_idx;
  logic [IDX_WIDTH-1:0]   second_idx;
  logic                   have_second;
  logic [SUM_WIDTH-1:0]   sum;
  logic [SUM_WIDTH-1:0]   second_x5;
  logic                   allelic;

  // Top-two scan; strict compares keep the lower base on ties.
  always_comb begin
    best        = counts_i[0];
    first_idx   = BASE_A;
    second      = '0;
    second_idx  = BASE_NONE;
    have_second = 1'b0;
    sum         = SUM_WIDTH'(counts_i[0]);
    for (int j = 1; j < NUM_BASES; j++) begin
      sum = sum + SUM_WIDTH'(counts_i[j]);
      if (counts_i[j] > best) begin
        second      = best;
        second_idx  = first_idx;
        have_second = 1'b1;
        best        = counts_i[j];
        first_idx   = IDX_WIDTH'(j + 1);
      end else if (!have_second || (counts_i[j] > second)) begin
        second      = counts_i[j];
        second_idx  = IDX_WIDTH'(j + 1);
        have_second = 1'b1;
      end
    end
  end

  // 5*second as shift-add; fits in SUM_WIDTH.
  assign second_x5 = {1'b0, second, 2'b00} + SUM_WIDTH'(second);
  assign allelic   = (sum != '0) && (second_x5 > sum);

  always_comb begin
    call_o.allelic = allelic;
    call_o.fix     = (ref_char_i != base_letter(first_idx)) || allelic;
    if (allelic) begin
      call_o.replacement = REP_WIDTH'(ALLELIC_BASE + ALLELIC_MUL * int'(first_idx)
                                      + int'(second_idx));
    end else begin
      call_o.replacement = base_letter(first_idx);
    end
  end

endmodule

@@ sv/pileup_consensus_fix_caller_core.sv @@
// Pileup consensus fix caller, registered single pass.
// An accepted site passes through the input register and then the result register, which drives the output.
// Throughput: one site per cycle, sustained, with the output consumer always ready.
// Reset (rst_ni low, asynchronous): pipeline valid flags and the previous fix
// location clear to zero; no clearing pass, the block accepts at once.
module pileup_consensus_fix_caller_core #(
  parameter int unsigned COUNT_WIDTH    = pcfc_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned LOCATION_WIDTH = pcfc_pkg::LOCATION_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  pcfc_site_if.sink  in_i,
  pcfc_fix_if.source out_o
);
  import pcfc_pkg::*;

  // Delta is computed modulo 2^(LOCATION_WIDTH+1), then fit to the 33-bit field.
  localparam int unsigned DN_WIDTH = LOCATION_WIDTH + 1;
  localparam int unsigned DW_WIDTH = (DN_WIDTH > DELTA_WIDTH) ? DN_WIDTH : DELTA_WIDTH;

  // ---------------------------------------------------------------------------
  // Input register stage. It loads whenever it is empty or hands its site on,
  // so a new transaction can enter every cycle.
  // ---------------------------------------------------------------------------
  logic                      s1_valid_q;
  logic [LOCATION_WIDTH-1:0] s1_loc_q;
  logic [REF_WIDTH-1:0]      s1_ref_q;
  logic [COUNT_WIDTH-1:0]    s1_cnt_q [NUM_BASES];
  logic                      s1_blk_q;

  logic in_fire;
  logic out_free;   // result register can take a new result this cycle
  logic s1_adv;     // site moves from input register to result register

  assign out_free   = !out_o.valid || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_loc_q    <= in_i.location;
      s1_ref_q    <= in_i.ref_char;
      s1_cnt_q[0] <= in_i.count_a;
      s1_cnt_q[1] <= in_i.count_c;
      s1_cnt_q[2] <= in_i.count_g;
      s1_cnt_q[3] <= in_i.count_t;
      s1_cnt_q[4] <= in_i.count_n;
      s1_blk_q    <= in_i.block_start;
    end
  end

  // ---------------------------------------------------------------------------
  // Consensus call: top two counts, allelic test, replacement byte.
  // ---------------------------------------------------------------------------
  pcfc_call_t call;

  pcfc_classify #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_classify (
    .ref_char_i (s1_ref_q),
    .counts_i   (s1_cnt_q),
    .call_o     (call)
  );

  // ---------------------------------------------------------------------------
  // Location delta against the last fix. Block start clears the previous fix
  // location ahead of this site, so its delta is location + 1.
  // ---------------------------------------------------------------------------
  logic [LOCATION_WIDTH-1:0] prev_fix_q;
  logic [LOCATION_WIDTH-1:0] prev_fix_d;
  logic [LOCATION_WIDTH-1:0] prev_eff;
  logic [DN_WIDTH-1:0]       delta_n;
  logic [DW_WIDTH-1:0]       delta_w;

  assign prev_eff = s1_blk_q ? '0 : prev_fix_q;
  assign delta_n  = {1'b0, s1_loc_q} - {1'b0, prev_eff} + DN_WIDTH'(1);
  assign delta_w  = DW_WIDTH'(delta_n);

  // The only state carried between sites; updates as the site leaves stage 1.
  always_comb begin
    prev_fix_d = prev_fix_q;
    if (s1_adv) begin
      prev_fix_d = call.fix ? s1_loc_q : prev_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_fix_q <= '0;
    end else begin
      prev_fix_q <= prev_fix_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. Non-fix sites report all-zero fields.
  // ---------------------------------------------------------------------------
  logic                   out_valid_q;
  logic                   fix_valid_q;
  logic [DELTA_WIDTH-1:0] loc_delta_q;
  logic [REP_WIDTH-1:0]   replacement_q;
  logic                   is_allelic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      fix_valid_q   <= call.fix;
      loc_delta_q   <= call.fix ? delta_w[DELTA_WIDTH-1:0] : '0;
      replacement_q <= call.fix ? call.replacement : '0;
      is_allelic_q  <= call.fix && call.allelic;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.fix_valid   = fix_valid_q;
  assign out_o.loc_delta   = loc_delta_q;
  assign out_o.replacement = replacement_q;
  assign out_o.is_allelic  = is_allelic_q;

`ifndef SYNTHESIS
  // A site held in stage 1 while the result register is stalled stays put.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q)
    else $error("stage 1 site dropped during output stall");

  // A fix moves the previous fix location to that site.
  a_prev_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && call.fix) |=> (prev_fix_q == $past(s1_loc_q)))
    else $error("previous fix location not updated");

  // Allelic sites are always fixes.
  a_allelic_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && is_allelic_q) |-> fix_valid_q)
    else $error("allelic result without fix");

  // Non-fix results carry zero fields.
  a_nofix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !fix_valid_q) |-> ((loc_delta_q == '0) && (replacement_q == '0)))
    else $error("non-fix result with nonzero fields");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the pileup consensus fix caller.
// A site driver pushes covered sites through the input channel; at every
// accepted transaction the bench computes the expected fix record from its
// own model of the caller and queues it. A sink process applies random
// backpressure, pops the oldest expectation for each output transaction and
// compares it field by field.
module tb;
  import pcfc_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH_DEF;
  localparam int unsigned LW = LOCATION_WIDTH_DEF;

  // Letter for each base index; index 0 is the "no base" dot.
  localparam logic [REF_WIDTH-1:0] CONSENSUS_LETTER [0:5] = '{".", "A", "C", "G", "T", "N"};

  // One covered site as the driver sees it. Counts are indexed by base code.
  typedef struct packed {
    logic [LW-1:0]                 location;
    logic [REF_WIDTH-1:0]          ref_char;
    logic [BASE_N:BASE_A][CW-1:0]  count;
    logic                          block_start;
  } site_t;

  // One fix record as the caller emits it.
  typedef struct packed {
    logic                   fix_valid;
    logic [DELTA_WIDTH-1:0] loc_delta;
    logic [REP_WIDTH-1:0]   replacement;
    logic                   is_allelic;
  } fix_t;

  logic clk_i;
  logic rst_ni;

  pcfc_site_if #(.COUNT_WIDTH(CW), .LOCATION_WIDTH(LW)) site_if ();
  pcfc_fix_if fix_if ();

  pileup_consensus_fix_caller_core #(
    .COUNT_WIDTH    (CW),
    .LOCATION_WIDTH (LW)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (site_if),
    .out_o  (fix_if)
  );

  // Expected fix records, oldest first, and the model's delta register.
  fix_t          pending_fixes[$];
  logic [LW-1:0] last_fix_loc;

  int unsigned fail_count;
  int unsigned fixes_seen;

  // Gap and stall enables; tests flip these to get runs with and without idling.
  bit sender_idling;
  bit sink_idling;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop. The slowest legal run is about 1200 sites, each with the longest
  // input gap and output stall the bench draws: well under half a
  // millisecond. This is ten times that.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Model of the caller for one site. Updates the delta register.
  function automatic fix_t call_site_fix(input site_t s);
    fix_t                 f;
    logic [IDX_WIDTH-1:0] top_idx;
    logic [IDX_WIDTH-1:0] run_idx;
    logic [CW-1:0]        top_cnt;
    logic [CW-1:0]        run_cnt;
    longint unsigned      total;
    bit                   allelic;
    if (s.block_start) last_fix_loc = '0;
    // Strict compares: on a tie the lower base index keeps its place.
    top_idx = BASE_A;
    top_cnt = s.count[BASE_A];
    run_idx = BASE_NONE;
    run_cnt = '0;
    total   = s.count[BASE_A];
    for (int b = BASE_C; b <= BASE_N; b++) begin
      total += s.count[b];
      if (s.count[b] > top_cnt) begin
        run_idx = top_idx;
        run_cnt = top_cnt;
        top_idx = IDX_WIDTH'(b);
        top_cnt = s.count[b];
      end else if (run_idx == BASE_NONE || s.count[b] > run_cnt) begin
        run_idx = IDX_WIDTH'(b);
        run_cnt = s.count[b];
      end
    end
    // second/sum > 0.2 in integers; an empty pileup is never allelic.
    allelic = (total != 0) && (longint'(ALLELIC_DEN) * run_cnt > total);
    f = '0;
    if (s.ref_char != CONSENSUS_LETTER[top_idx] || allelic) begin
      f.fix_valid   = 1'b1;
      f.loc_delta   = {1'b0, s.location} - {1'b0, last_fix_loc} + DELTA_WIDTH'(1);
      f.replacement = allelic ? REP_WIDTH'(ALLELIC_BASE + ALLELIC_MUL * top_idx + run_idx)
                              : CONSENSUS_LETTER[top_idx];
      f.is_allelic  = allelic;
      last_fix_loc  = s.location;
    end
    return f;
  endfunction

  // Drives one site and returns at the edge where it is accepted. Valid stays
  // high afterwards so back-to-back sites follow without a drop in valid.
  task automatic send_site(input site_t s);
    int unsigned gap;
    gap = sender_idling ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      site_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    site_if.valid       <= 1'b1;
    site_if.location    <= s.location;
    site_if.ref_char    <= s.ref_char;
    site_if.count_a     <= s.count[BASE_A];
    site_if.count_c     <= s.count[BASE_C];
    site_if.count_g     <= s.count[BASE_G];
    site_if.count_t     <= s.count[BASE_T];
    site_if.count_n     <= s.count[BASE_N];
    site_if.block_start <= s.block_start;
    do @(posedge clk_i); while (site_if.ready !== 1'b1);
    pending_fixes.insert(pending_fixes.size(), call_site_fix(s));
  endtask

  task automatic send_counts(input logic [LW-1:0] loc, input logic [REF_WIDTH-1:0] ref_byte,
                             input logic [CW-1:0] a, input logic [CW-1:0] c,
                             input logic [CW-1:0] g, input logic [CW-1:0] t,
                             input logic [CW-1:0] n, input bit start);
    site_t s;
    s.location    = loc;
    s.ref_char    = ref_byte;
    s.count       = {n, t, g, c, a};
    s.block_start = start;
    send_site(s);
  endtask

  // Drops valid and holds off until every expected record is back.
  task automatic wait_fixes_drained();
    site_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_fixes.size() != 0);
  endtask

  // A plausible pileup: mostly one dominant base agreeing with the reference,
  // with two-base sites near the allelic threshold, empty sites, random and
  // saturated counts, and mismatching or odd reference bytes mixed in.
  function automatic site_t make_pileup(input logic [LW-1:0] loc, input bit start);
    site_t       s;
    int unsigned kind;
    int unsigned dom;
    int unsigned sec;
    int unsigned c1;
    int unsigned pick;
    s.location    = loc;
    s.block_start = start;
    s.count       = '0;
    kind = $urandom_range(0, 9);
    dom  = $urandom_range(1, 5);
    sec  = $urandom_range(1, 5);
    case (kind)
      0: begin
        // uncovered by reads, all zero
      end
      1, 2, 3, 4, 5: begin
        c1 = $urandom_range(1, 200);
        for (int b = BASE_A; b <= BASE_N; b++) s.count[b] = CW'($urandom_range(0, c1 / 12));
        s.count[dom] = CW'(c1);
      end
      6, 7: begin
        c1 = $urandom_range(4, 400);
        for (int b = BASE_A; b <= BASE_N; b++) s.count[b] = CW'($urandom_range(0, 3));
        s.count[dom] = CW'(c1);
        s.count[sec] = CW'($urandom_range(c1 / 8, c1));
      end
      8: begin
        for (int b = BASE_A; b <= BASE_N; b++) s.count[b] = CW'($urandom);
      end
      default: begin
        for (int b = BASE_A; b <= BASE_N; b++) begin
          pick = $urandom_range(0, 2);
          s.count[b] = (pick == 0) ? '0 : (pick == 1) ? '1 : CW'($urandom);
        end
      end
    endcase
    pick = $urandom_range(0, 9);
    if (pick <= 6)       s.ref_char = CONSENSUS_LETTER[dom];
    else if (pick == 7)  s.ref_char = CONSENSUS_LETTER[$urandom_range(1, 5)];
    else if (pick == 8)  s.ref_char = REF_WIDTH'($urandom);
    else                 s.ref_char = REF_WIDTH'(ALLELIC_BASE + ALLELIC_MUL * $urandom_range(1, 5)
                                                 + $urandom_range(1, 5));
    return s;
  endfunction

  // Hand-picked sites: each base as consensus, ties, the allelic threshold,
  // empty and saturated pileups, odd reference bytes and delta corner cases.
  task automatic test_directed_sites();
    logic [CW-1:0] mx;
    mx = '1;
    sender_idling = 1'b1;
    sink_idling   = 1'b1;
    // Empty pileup calls A and is never allelic.
    send_counts(100, "A", 0, 0, 0, 0, 0, 1'b1);
    send_counts(101, "C", 0, 0, 0, 0, 0, 1'b0);
    // Each base as clean consensus matching the reference: no fix.
    send_counts(102, "A", 10, 0, 0, 0, 0, 1'b0);
    send_counts(103, "C", 0, 10, 0, 0, 0, 1'b0);
    send_counts(104, "G", 0, 0, 10, 0, 0, 1'b0);
    send_counts(105, "T", 0, 0, 0, 10, 0, 1'b0);
    send_counts(106, "N", 0, 0, 0, 0, 10, 1'b0);
    // Consensus differs from reference.
    send_counts(108, "A", 0, 0, 0, 10, 0, 1'b0);
    // Tie: A wins, C is second, allelic.
    send_counts(109, "A", 5, 5, 0, 0, 0, 1'b0);
    // Exactly one fifth is not allelic; just above is.
    send_counts(110, "A", 8, 2, 0, 0, 0, 1'b0);
    send_counts(111, "A", 7, 2, 0, 0, 0, 1'b0);
    // Saturated counts.
    send_counts(112, "A", mx, mx, mx, mx, mx, 1'b0);
    send_counts(113, "A", mx, mx, 0, 0, 0, 1'b0);
    send_counts(114, "G", 0, 0, mx, mx, mx, 1'b0);
    send_counts(115, "N", 0, 0, 0, 0, mx, 1'b0);
    // Reference bytes outside the letter set.
    send_counts(116, 8'h00, 1, 0, 0, 0, 0, 1'b0);
    send_counts(117, 8'hFF, 1, 0, 0, 0, 0, 1'b0);
    send_counts(118, 8'd93, 5, 5, 0, 0, 0, 1'b0);
    // Location behind the previous fix: delta wraps.
    send_counts(50, "C", 1, 0, 0, 0, 0, 1'b0);
    // Block start with a fix at the top location: delta is location + 1.
    send_counts('1, "C", 1, 0, 0, 0, 0, 1'b1);
    send_counts(0, "C", 1, 0, 0, 0, 0, 1'b0);
    // Block start on a site without a fix still clears the register.
    send_counts(3, "A", 3, 0, 0, 0, 0, 1'b1);
    send_counts(7, "G", 3, 0, 0, 0, 0, 1'b0);
    send_counts(0, "T", 3, 0, 0, 0, 0, 1'b1);
    wait_fixes_drained();
  endtask

  // Blocks of ascending covered sites, a block start on most first sites,
  // with idling turned on or off per block.
  task automatic test_block_runs();
    logic [LW-1:0] loc;
    int unsigned   run_len;
    int unsigned   sent;
    sent = 0;
    while (sent < 800) begin
      sender_idling = ($urandom_range(0, 3) != 0);
      sink_idling   = ($urandom_range(0, 3) != 0);
      loc = ($urandom_range(0, 7) == 0) ? LW'(32'hFFFF_FFFF - $urandom_range(0, 40))
                                        : LW'($urandom);
      run_len = $urandom_range(5, 40);
      for (int i = 0; i < run_len; i++) begin
        send_site(make_pileup(loc, (i == 0) && ($urandom_range(0, 4) != 0)));
        loc += ($urandom_range(0, 7) == 0) ? LW'($urandom_range(2, 5000)) : LW'(1);
        sent++;
      end
    end
    wait_fixes_drained();
  endtask

  // Full-rate input against a stalling sink, then full rate on both sides.
  task automatic test_backpressure_drain();
    logic [LW-1:0] loc;
    loc = LW'($urandom);
    sender_idling = 1'b0;
    sink_idling   = 1'b1;
    for (int i = 0; i < 60; i++) begin
      send_site(make_pileup(loc, i == 0));
      loc += LW'($urandom_range(1, 3));
    end
    wait_fixes_drained();
    sink_idling = 1'b0;
    for (int i = 0; i < 60; i++) begin
      send_site(make_pileup(loc, 1'b0));
      loc += LW'(1);
    end
    wait_fixes_drained();
  endtask

  // Unstructured sites: random locations in any order, random bytes and
  // counts that are either full range or tiny so ties are common.
  task automatic test_random_sites();
    site_t s;
    for (int i = 0; i < 300; i++) begin
      if (i % 50 == 0) begin
        sender_idling = ($urandom_range(0, 2) != 0);
        sink_idling   = ($urandom_range(0, 2) != 0);
      end
      s.location    = LW'($urandom);
      s.block_start = ($urandom_range(0, 7) == 0);
      for (int b = BASE_A; b <= BASE_N; b++)
        s.count[b] = $urandom_range(0, 1) ? CW'($urandom) : CW'($urandom_range(0, 3));
      s.ref_char = $urandom_range(0, 1) ? REF_WIDTH'($urandom)
                                        : CONSENSUS_LETTER[$urandom_range(1, 5)];
      send_site(s);
    end
    wait_fixes_drained();
  endtask

  // Output sink: draws a stall after every transaction while sink idling is on
  // and checks each record against the oldest expectation.
  initial begin : fix_sink
    int unsigned stall_left;
    fix_t        want;
    stall_left   = 0;
    fix_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (fix_if.valid === 1'b1 && fix_if.ready === 1'b1) begin
        if (pending_fixes.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", fixes_seen));
        end else begin
          want = pending_fixes.pop_front();
          if (fix_if.fix_valid !== want.fix_valid)
            report_mismatch($sformatf("result %0d fix_valid got %0b want %0b",
                                      fixes_seen, fix_if.fix_valid, want.fix_valid));
          if (fix_if.loc_delta !== want.loc_delta)
            report_mismatch($sformatf("result %0d loc_delta got 0x%0h want 0x%0h",
                                      fixes_seen, fix_if.loc_delta, want.loc_delta));
          if (fix_if.replacement !== want.replacement)
            report_mismatch($sformatf("result %0d replacement got 0x%0h want 0x%0h",
                                      fixes_seen, fix_if.replacement, want.replacement));
          if (fix_if.is_allelic !== want.is_allelic)
            report_mismatch($sformatf("result %0d is_allelic got %0b want %0b",
                                      fixes_seen, fix_if.is_allelic, want.is_allelic));
        end
        fixes_seen++;
        stall_left = sink_idling ? $urandom_range(0, 13) : 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      fix_if.ready <= (stall_left == 0);
    end
  end

  // Sequencer: reset, then each test in turn, then the final verdict.
  initial begin
    fail_count   = 0;
    fixes_seen   = 0;
    last_fix_loc = '0;
    sender_idling = 1'b1;
    sink_idling   = 1'b1;
    rst_ni              <= 1'b0;
    site_if.valid       <= 1'b0;
    site_if.location    <= '0;
    site_if.ref_char    <= '0;
    site_if.count_a     <= '0;
    site_if.count_c     <= '0;
    site_if.count_g     <= '0;
    site_if.count_t     <= '0;
    site_if.count_n     <= '0;
    site_if.block_start <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_sites();
    test_block_runs();
    test_backpressure_drain();
    test_random_sites();

    // Everything is back; watch the two-stage pipe for anything stray.
    wait_fixes_drained();
    repeat (4) @(posedge clk_i);
    if (pending_fixes.size() != 0)
      report_mismatch($sformatf("%0d expected records never arrived", pending_fixes.size()));

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/pcfc_pkg.sv
sv/pcfc_site_if.sv
sv/pcfc_fix_if.sv
sv/pcfc_classify.sv
sv/pileup_consensus_fix_caller_core.sv
tb/tb.sv
